// File: rtl/core/tgaat_pkg.sv
// Shared types and constants of the tilt-gated accelerometer angle tracker.
`default_nettype none

package tgaat_pkg;

	localparam int SampleW = 8;
	localparam int StatusW = 8;
	localparam int AvgW    = 16;
	localparam int AngleW  = 16;
	localparam int CountW  = 8;
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;
	localparam int DivSteps = 16;
	localparam int DivCntW  = $clog2(DivSteps);

	localparam int TiltBit = 4;
	localparam logic [CountW-1:0] TiltLimitReset = 8'd10;
	localparam logic [CountW-1:0] CountStuck     = 8'hFF;

	localparam logic signed [AngleW-1:0] AtanK1 = 16'sd2847;
	localparam logic signed [AngleW-1:0] AtanK2 = 16'sd11039;

	localparam logic [AngleW-1:0] AngleDiagPos = 16'd8192;
	localparam logic [AngleW-1:0] AngleDiagNeg = 16'd40960;
	localparam logic [AngleW-1:0] AngleZero    = 16'd0;
	localparam logic [AngleW-1:0] AngleQuarter = 16'd16384;
	localparam logic [AngleW-1:0] AngleHalf    = 16'd32768;
	localparam logic [AngleW-1:0] AngleThreeQ  = 16'd49152;

	localparam logic RegTiltLimit = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_MUL1,
		ST_COEF,
		ST_MUL2,
		ST_ANGLE,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/tgaat_reading_if.sv
// Handshake channel that carries one accelerometer reading per beat.
`default_nettype none

interface tgaat_reading_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tgaat_pkg::SampleW-1:0]   sample_x;
	logic signed [tgaat_pkg::SampleW-1:0]   sample_y;
	logic        [tgaat_pkg::StatusW-1:0]   status_byte;

	modport source (output valid, sample_x, sample_y, status_byte, input ready);
	modport sink (input valid, sample_x, sample_y, status_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tgaat_result_if.sv
// Handshake channel that carries one angle result per beat.
`default_nettype none

interface tgaat_result_if;
	logic                                valid;
	logic                                ready;
	logic [tgaat_pkg::AngleW-1:0]        heading;
	logic [tgaat_pkg::CountW-1:0]        tilt_run;
	logic                                tilted;

	modport source (output valid, heading, tilt_run, tilted, input ready);
	modport sink (input valid, heading, tilt_run, tilted, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tilt_gated_accel_angle_tracker.sv
// Tilt-gated accelerometer angle tracker: sequencer, shared divider and multiplier, APB register.
// A reading with the tilt bit set only advances the tilt counter and goes straight to the finish
// state. Any other reading updates both axis averages and then runs a four-quadrant atan2: a
// set-up step, a restoring divider that yields one quotient bit a cycle, and then the MUL1, COEF,
// MUL2 and ANGLE states, which share a single 16 by 16 multiplier. When the two new averages are
// equal the divider and multiplier are skipped. The next reading is taken while a finished result
// still waits in the output register. The tilt limit is written through the APB port at any byte
// address with paddr[2] clear, that is 0 to 3, and resets to 10.
`default_nettype none

module tilt_gated_accel_angle_tracker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tgaat_pkg::ApbAddrW-1:0]    paddr,
	input  wire logic [tgaat_pkg::ApbDataW-1:0]    pwdata,
	output logic      [tgaat_pkg::ApbDataW-1:0]    prdata,
	output logic                                   pready,
	tgaat_reading_if.sink                          reading,
	tgaat_result_if.source                         result
);

	tgaat_pkg::state_t state_q, state_d;

	logic [tgaat_pkg::CountW-1:0]         limit_q;
	logic [tgaat_pkg::CountW-1:0]         cnt_q;
	logic                                 tilted_q;
	logic signed [tgaat_pkg::AvgW-1:0]    avg_x_q, avg_y_q;
	logic [tgaat_pkg::AngleW-1:0]         angle_q;
	logic                                 xmaj_q;
	logic                                 neg_q;
	logic [tgaat_pkg::AvgW:0]             den_q, rem_q;
	logic [tgaat_pkg::AvgW-1:0]           quo_q;
	logic [tgaat_pkg::DivCntW-1:0]        div_cnt_q;
	logic signed [2*tgaat_pkg::AvgW-1:0]  prod_q;
	logic signed [tgaat_pkg::AvgW-1:0]    coef_q;

	logic                                 out_valid_q;
	logic [tgaat_pkg::AngleW-1:0]         out_angle_q;
	logic [tgaat_pkg::CountW-1:0]         out_count_q;
	logic                                 out_tilted_q;

	logic in_acc, out_load, cfg_wr;
	logic tilt_in;
	logic [tgaat_pkg::AvgW:0] abs_x, abs_y, trial;
	logic div_ge;
	logic signed [tgaat_pkg::AvgW-1:0] ratio, ratio_nabs, mul_a, mul_b, u_val;

	function automatic logic signed [tgaat_pkg::AvgW-1:0] next_avg(
		input logic signed [tgaat_pkg::AvgW-1:0]    avg,
		input logic signed [tgaat_pkg::SampleW-1:0] smp
	);
		logic signed [tgaat_pkg::AvgW+1:0] qt;
		logic signed [tgaat_pkg::AvgW+1:0] sum;
		qt = 18'(avg >>> 2);
		qt = qt + ((avg[15] && (avg[1:0] != 2'b00)) ? 18'sd1 : 18'sd0);
		sum = qt + (qt <<< 1) + (18'(smp) <<< 6);
		return sum[tgaat_pkg::AvgW-1:0];
	endfunction

	function automatic logic [tgaat_pkg::AvgW:0] abs17(
		input logic signed [tgaat_pkg::AvgW-1:0] v
	);
		logic signed [tgaat_pkg::AvgW:0] e;
		e = 17'(v);
		return v[tgaat_pkg::AvgW-1] ? 17'(-e) : 17'(e);
	endfunction

	assign in_acc   = reading.valid && reading.ready;
	assign tilt_in  = reading.status_byte[tgaat_pkg::TiltBit];
	assign out_load = (state_q == tgaat_pkg::ST_FIN) && (!out_valid_q || result.ready);
	assign cfg_wr   = psel && penable && pwrite && pready
		&& (paddr[2] == tgaat_pkg::RegTiltLimit);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tgaat_pkg::RegTiltLimit)
		? {{(tgaat_pkg::ApbDataW-tgaat_pkg::CountW){1'b0}}, limit_q}
		: '0;

	assign abs_x = abs17(avg_x_q);
	assign abs_y = abs17(avg_y_q);

	assign trial  = (div_cnt_q == '0) ? rem_q : {rem_q[tgaat_pkg::AvgW-1:0], 1'b0};
	assign div_ge = (trial >= den_q);

	assign ratio      = neg_q ? 16'(-quo_q) : quo_q;
	assign ratio_nabs = ratio[tgaat_pkg::AvgW-1] ? ratio : 16'(-ratio);
	assign mul_a      = (state_q == tgaat_pkg::ST_MUL2) ? coef_q : tgaat_pkg::AtanK1;
	assign mul_b      = (state_q == tgaat_pkg::ST_MUL2) ? ratio : ratio_nabs;
	assign u_val      = prod_q[30:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgaat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		reading.ready = 1'b0;
		unique case (state_q)
			tgaat_pkg::ST_IDLE: begin
				reading.ready = 1'b1;
				if (reading.valid) begin
					state_d = tilt_in ? tgaat_pkg::ST_FIN : tgaat_pkg::ST_SETUP;
				end
			end
			tgaat_pkg::ST_SETUP: begin
				state_d = (avg_x_q == avg_y_q) ? tgaat_pkg::ST_FIN : tgaat_pkg::ST_DIV;
			end
			tgaat_pkg::ST_DIV: begin
				if (div_cnt_q == tgaat_pkg::DivCntW'(tgaat_pkg::DivSteps - 1)) begin
					state_d = tgaat_pkg::ST_MUL1;
				end
			end
			tgaat_pkg::ST_MUL1:  state_d = tgaat_pkg::ST_COEF;
			tgaat_pkg::ST_COEF:  state_d = tgaat_pkg::ST_MUL2;
			tgaat_pkg::ST_MUL2:  state_d = tgaat_pkg::ST_ANGLE;
			tgaat_pkg::ST_ANGLE: state_d = tgaat_pkg::ST_FIN;
			tgaat_pkg::ST_FIN: begin
				if (out_load) begin
					state_d = tgaat_pkg::ST_IDLE;
				end
			end
			default: state_d = tgaat_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= tgaat_pkg::TiltLimitReset;
			cnt_q    <= '0;
			avg_x_q  <= '0;
			avg_y_q  <= '0;
			angle_q  <= '0;
			tilted_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				limit_q <= pwdata[tgaat_pkg::CountW-1:0];
			end
			if (in_acc) begin
				tilted_q <= tilt_in;
				if (tilt_in) begin
					cnt_q <= (cnt_q < limit_q) ? 8'(cnt_q + 8'd1) : tgaat_pkg::CountStuck;
				end else begin
					cnt_q   <= '0;
					avg_x_q <= next_avg(avg_x_q, reading.sample_x);
					avg_y_q <= next_avg(avg_y_q, reading.sample_y);
				end
			end
			if (state_q == tgaat_pkg::ST_SETUP && avg_x_q == avg_y_q) begin
				if (avg_y_q > 0) begin
					angle_q <= tgaat_pkg::AngleDiagPos;
				end else if (avg_y_q < 0) begin
					angle_q <= tgaat_pkg::AngleDiagNeg;
				end else begin
					angle_q <= tgaat_pkg::AngleZero;
				end
			end
			if (state_q == tgaat_pkg::ST_ANGLE) begin
				if (xmaj_q) begin
					angle_q <= u_val + (avg_x_q[tgaat_pkg::AvgW-1]
						? tgaat_pkg::AngleHalf : tgaat_pkg::AngleZero);
				end else begin
					angle_q <= (avg_y_q[tgaat_pkg::AvgW-1]
						? tgaat_pkg::AngleThreeQ : tgaat_pkg::AngleQuarter) - u_val;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			tgaat_pkg::ST_SETUP: begin
				xmaj_q    <= (abs_x > abs_y);
				neg_q     <= avg_x_q[tgaat_pkg::AvgW-1] ^ avg_y_q[tgaat_pkg::AvgW-1];
				rem_q     <= (abs_x > abs_y) ? abs_y : abs_x;
				den_q     <= (abs_x > abs_y) ? abs_x : abs_y;
				quo_q     <= '0;
				div_cnt_q <= '0;
			end
			tgaat_pkg::ST_DIV: begin
				rem_q     <= div_ge ? 17'(trial - den_q) : trial;
				quo_q     <= {quo_q[tgaat_pkg::AvgW-2:0], div_ge};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			tgaat_pkg::ST_MUL1, tgaat_pkg::ST_MUL2: begin
				prod_q <= mul_a * mul_b;
			end
			tgaat_pkg::ST_COEF: begin
				coef_q <= tgaat_pkg::AtanK2 + $signed(prod_q[30:15]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_angle_q  <= angle_q;
			out_count_q  <= cnt_q;
			out_tilted_q <= tilted_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.heading  = out_angle_q;
	assign result.tilt_run = out_count_q;
	assign result.tilted   = out_tilted_q;

`ifndef SYNTHESIS
	a_untilted_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !tilt_in) |=> (cnt_q == '0))
		else $error("tilt counter not cleared by an untilted reading");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgaat_pkg::ST_DIV
			&& div_cnt_q == tgaat_pkg::DivCntW'(tgaat_pkg::DivSteps - 1))
		|=> (state_q == tgaat_pkg::ST_MUL1))
		else $error("divider did not finish after its last step");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgaat_pkg::ST_DIV) |-> (rem_q <= den_q))
		else $error("divider remainder exceeds divisor");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tgaat_pkg::ST_FIN))
		else $error("result beat raised outside the finish state");
`endif

endmodule

`default_nettype wire
